// ----- rtl/lrbc_pkg.sv -----
package lrbc_pkg;

  // Slot and guest geometry.
  localparam int NUM_SLOTS    = 16;
  localparam int NUM_VOLATILE = 8;
  localparam int NUM_GUESTS   = 32;
  localparam int GUEST_W      = $clog2(NUM_GUESTS);
  localparam int SLOT_W       = $clog2(NUM_SLOTS);
  localparam int SLOT_PORT_W  = 4;
  localparam int FRESH_W      = $clog2(NUM_SLOTS + 1);
  localparam int STAMP_W      = 32;

  // Result limits per input item.
  localparam int MAX_RESULTS = 32;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  // Command queue between front and back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Input mode codes.
  localparam int MODE_W = 3;
  localparam logic [MODE_W-1:0] MODE_READ          = 3'd0;
  localparam logic [MODE_W-1:0] MODE_WRITE         = 3'd1;
  localparam logic [MODE_W-1:0] MODE_FLUSH         = 3'd2;
  localparam logic [MODE_W-1:0] MODE_FLUSH_RELEASE = 3'd3;
  localparam logic [MODE_W-1:0] MODE_FLUSH_RESTORE = 3'd4;
  localparam logic [MODE_W-1:0] MODE_RESET         = 3'd5;

  localparam int ACT_W = 3;

  typedef enum logic [ACT_W-1:0] {
    ACT_DONE      = 3'd0,
    ACT_LOAD      = 3'd1,
    ACT_ZERO      = 3'd2,
    ACT_WRITEBACK = 3'd3,
    ACT_SAVE      = 3'd4,
    ACT_RESTORE   = 3'd5,
    ACT_OPEN      = 3'd6
  } action_t;

  typedef enum logic [2:0] {
    CMD_ACCESS,
    CMD_FLUSH,
    CMD_FLUSH_REL,
    CMD_FLUSH_RESTORE,
    CMD_RESET,
    CMD_NOP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [GUEST_W-1:0] guest;
    logic               dirty;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    action_t            action;
    logic [SLOT_W-1:0]  slot;
    logic [GUEST_W-1:0] guest;
  } result_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACCESS,
    ST_SCAN,
    ST_EVICT,
    ST_BIND,
    ST_OPEN,
    ST_SAVE,
    ST_LOAD,
    ST_FLUSH,
    ST_RESTORE,
    ST_RESET,
    ST_FINISH
  } state_t;

endpackage

// ----- rtl/lru_register_binding_cache.sv -----
// An item passes the front holding register and the command queue to the slot
// sequencer, which works on one item at a time; new items are taken meanwhile until
// the queue is full. Each result is held until the next result of its item is made or
// the item's final step. A hit goes through access and finish; a miss binds a fresh,
// empty or LRU slot, then opens, saves and loads; a flush walks every slot in turn.
// Reset (rst, synchronous) empties all bindings, the queue and the outputs.
module lru_register_binding_cache (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_stall,
  input  logic [lrbc_pkg::MODE_W-1:0]         mode,
  input  logic [lrbc_pkg::GUEST_W-1:0]        guest_reg,
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output logic [lrbc_pkg::ACT_W-1:0]          action,
  output logic [lrbc_pkg::SLOT_PORT_W-1:0]    slot,
  output logic [lrbc_pkg::GUEST_W-1:0]        guest_index,
  output logic                                last
);

  logic                push_valid;
  lrbc_pkg::cmd_t      push_cmd;
  lrbc_pkg::q_status_t q_status;
  lrbc_pkg::cmd_t      head;
  logic                pop;

  // Front end: accepts and classifies items.
  lrbc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .mode       (mode),
    .guest_reg  (guest_reg),
    .q_status   (q_status),
    .push_valid (push_valid),
    .push_cmd   (push_cmd)
  );

  // Command queue between the two halves.
  lrbc_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .pop        (pop),
    .head       (head),
    .status     (q_status)
  );

  // Back end: binding state and action sequencer.
  lrbc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_status    (q_status),
    .head        (head),
    .pop         (pop),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .action      (action),
    .slot        (slot),
    .guest_index (guest_index),
    .last        (last)
  );

`ifndef NO_ASSERTIONS
  // An accepted item is captured by the front stage.
  a_front_capture: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> push_valid)
    else $error("accepted item not captured by the front stage");

  // The back end never pops an empty queue.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_status.empty)
    else $error("pop from an empty command queue");

  // A done result is always the final result of its item.
  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (action != lrbc_pkg::ACT_DONE) || last)
    else $error("done result without the last flag");
`endif

endmodule

// ----- rtl/lrbc_front.sv -----
module lrbc_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_stall,
  input  logic [lrbc_pkg::MODE_W-1:0]  mode,
  input  logic [lrbc_pkg::GUEST_W-1:0] guest_reg,
  input  lrbc_pkg::q_status_t        q_status,
  output logic                       push_valid,
  output lrbc_pkg::cmd_t             push_cmd
);

  logic           held_valid;
  lrbc_pkg::cmd_t held_cmd;
  lrbc_pkg::cmd_t cmd_dec;

  // The holding stage blocks new transfers only while the queue is full.
  assign req_stall  = held_valid && q_status.full;
  assign push_valid = held_valid;
  assign push_cmd   = held_cmd;

  // Classify the incoming item into a command for the back end.
  always_comb begin
    cmd_dec.guest = guest_reg;
    cmd_dec.dirty = 1'b0;
    unique case (mode)
      lrbc_pkg::MODE_READ: begin
        cmd_dec.kind = lrbc_pkg::CMD_ACCESS;
      end
      lrbc_pkg::MODE_WRITE: begin
        cmd_dec.kind  = lrbc_pkg::CMD_ACCESS;
        cmd_dec.dirty = (guest_reg != '0);
      end
      lrbc_pkg::MODE_FLUSH: begin
        cmd_dec.kind = lrbc_pkg::CMD_FLUSH;
      end
      lrbc_pkg::MODE_FLUSH_RELEASE: begin
        cmd_dec.kind = lrbc_pkg::CMD_FLUSH_REL;
      end
      lrbc_pkg::MODE_FLUSH_RESTORE: begin
        cmd_dec.kind = lrbc_pkg::CMD_FLUSH_RESTORE;
      end
      lrbc_pkg::MODE_RESET: begin
        cmd_dec.kind = lrbc_pkg::CMD_RESET;
      end
      default: begin
        cmd_dec.kind = lrbc_pkg::CMD_NOP;
      end
    endcase
  end

  // Holding register in front of the command queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!req_stall) begin
      held_valid <= req_valid;
    end
    if (req_valid && !req_stall) begin
      held_cmd <= cmd_dec;
    end
  end

endmodule

// ----- rtl/lrbc_fifo.sv -----
module lrbc_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_valid,
  input  lrbc_pkg::cmd_t      push_cmd,
  input  logic                pop,
  output lrbc_pkg::cmd_t      head,
  output lrbc_pkg::q_status_t status
);

  lrbc_pkg::cmd_t                   entries [lrbc_pkg::QUEUE_DEPTH];
  logic [lrbc_pkg::QPTR_W-1:0]      wr_ptr;
  logic [lrbc_pkg::QPTR_W-1:0]      rd_ptr;
  logic [lrbc_pkg::QCNT_W-1:0]      count;
  logic                             do_push;
  logic                             do_pop;

  assign status.full  = (count == lrbc_pkg::QCNT_W'(lrbc_pkg::QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign head         = entries[rd_ptr];

  assign do_push = push_valid && !status.full;
  assign do_pop  = pop && !status.empty;

  // Pointers wrap at the queue depth.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        entries[wr_ptr] <= push_cmd;
        if (wr_ptr == lrbc_pkg::QPTR_W'(lrbc_pkg::QUEUE_DEPTH - 1)) begin
          wr_ptr <= '0;
        end else begin
          wr_ptr <= wr_ptr + 1'b1;
        end
      end
      if (do_pop) begin
        if (rd_ptr == lrbc_pkg::QPTR_W'(lrbc_pkg::QUEUE_DEPTH - 1)) begin
          rd_ptr <= '0;
        end else begin
          rd_ptr <= rd_ptr + 1'b1;
        end
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!do_push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/lrbc_back.sv -----
module lrbc_back (
  input  logic                              clk,
  input  logic                              rst,
  input  lrbc_pkg::q_status_t               q_status,
  input  lrbc_pkg::cmd_t                    head,
  output logic                              pop,
  output logic                              rsp_valid,
  input  logic                              rsp_stall,
  output logic [lrbc_pkg::ACT_W-1:0]        action,
  output logic [lrbc_pkg::SLOT_PORT_W-1:0]  slot,
  output logic [lrbc_pkg::GUEST_W-1:0]      guest_index,
  output logic                              last
);

  localparam int SW = lrbc_pkg::SLOT_W;
  localparam int GW = lrbc_pkg::GUEST_W;
  localparam int TW = lrbc_pkg::STAMP_W;

  lrbc_pkg::state_t state;
  lrbc_pkg::state_t state_next;
  lrbc_pkg::cmd_t   cmd;

  // Binding state.
  logic [lrbc_pkg::NUM_SLOTS-1:0]  slot_valid;
  logic [lrbc_pkg::NUM_SLOTS-1:0]  slot_dirty;
  logic [GW-1:0]                   slot_guest [lrbc_pkg::NUM_SLOTS];
  logic [TW-1:0]                   slot_stamp [lrbc_pkg::NUM_SLOTS];
  logic [SW-1:0]                   guest_map [lrbc_pkg::NUM_GUESTS];
  logic [lrbc_pkg::NUM_GUESTS-1:0] guest_mapped;
  logic [TW-1:0]                   stamp_counter;
  logic [lrbc_pkg::FRESH_W-1:0]    fresh_ptr;
  logic                            frame_open;

  // Sequencer working registers.
  logic [SW-1:0] idx;
  logic [SW-1:0] best;
  logic [TW-1:0] best_stamp;
  logic [SW-1:0] victim;
  logic          took_empty;
  logic          need_open;

  // Result hold stage and output register.
  logic                        hold_valid;
  lrbc_pkg::result_t           hold;
  logic [lrbc_pkg::CNT_W-1:0]  count;
  logic                        out_valid;
  lrbc_pkg::result_t           out_res;
  logic                        out_last;

  // Step controls.
  logic              advance;
  logic              produce;
  lrbc_pkg::result_t prod_res;
  logic              finish;
  logic              count_ok;
  logic              push;
  lrbc_pkg::result_t push_res;
  logic              push_last;

  // Derived views of the slot under the scan index.
  logic          idx_last;
  logic          hit;
  logic [SW-1:0] hit_slot;
  logic          fresh_free;
  logic [TW-1:0] cur_stamp;
  logic [GW-1:0] cur_guest;
  logic          cur_valid;
  logic          cur_dirty;
  logic          scan_lower;
  logic [SW-1:0] best_pick;
  logic          flush_skip;
  logic          flush_restore;
  logic          victim_vol;
  logic          idx_vol;

  function automatic logic slot_is_scratch(input logic [SW-1:0] s);
    return int'(s) < lrbc_pkg::NUM_VOLATILE;
  endfunction

  assign advance    = !out_valid || !rsp_stall;
  assign idx_last   = (idx == SW'(lrbc_pkg::NUM_SLOTS - 1));
  assign hit        = guest_mapped[cmd.guest];
  assign hit_slot   = guest_map[cmd.guest];
  assign fresh_free = (fresh_ptr < lrbc_pkg::FRESH_W'(lrbc_pkg::NUM_SLOTS));
  assign cur_stamp  = slot_stamp[idx];
  assign cur_guest  = slot_guest[idx];
  assign cur_valid  = slot_valid[idx];
  assign cur_dirty  = slot_dirty[idx];
  assign scan_lower = (cur_stamp < best_stamp);
  assign best_pick  = scan_lower ? idx : best;
  assign victim_vol = slot_is_scratch(victim);
  assign idx_vol    = slot_is_scratch(idx);
  assign flush_skip = !cur_valid || ((cmd.kind == lrbc_pkg::CMD_FLUSH_REL) && !idx_vol);
  assign flush_restore = !flush_skip && (cmd.kind == lrbc_pkg::CMD_FLUSH_RESTORE) && !idx_vol;

  // Next-state logic of the sequencer.
  always_comb begin
    state_next = state;
    if (advance) begin
      unique case (state)
        lrbc_pkg::ST_IDLE: begin
          if (!q_status.empty) begin
            unique case (head.kind) inside
              lrbc_pkg::CMD_ACCESS: state_next = lrbc_pkg::ST_ACCESS;
              lrbc_pkg::CMD_FLUSH, lrbc_pkg::CMD_FLUSH_REL,
              lrbc_pkg::CMD_FLUSH_RESTORE: state_next = lrbc_pkg::ST_FLUSH;
              lrbc_pkg::CMD_RESET: state_next = lrbc_pkg::ST_RESET;
              default: state_next = lrbc_pkg::ST_FINISH;
            endcase
          end
        end
        lrbc_pkg::ST_ACCESS: begin
          if (hit) begin
            state_next = lrbc_pkg::ST_FINISH;
          end else if (fresh_free) begin
            state_next = lrbc_pkg::ST_BIND;
          end else begin
            state_next = lrbc_pkg::ST_SCAN;
          end
        end
        lrbc_pkg::ST_SCAN: begin
          if (!cur_valid) begin
            state_next = lrbc_pkg::ST_BIND;
          end else if (idx_last) begin
            state_next = lrbc_pkg::ST_EVICT;
          end
        end
        lrbc_pkg::ST_EVICT:   state_next = lrbc_pkg::ST_BIND;
        lrbc_pkg::ST_BIND:    state_next = lrbc_pkg::ST_OPEN;
        lrbc_pkg::ST_OPEN:    state_next = lrbc_pkg::ST_SAVE;
        lrbc_pkg::ST_SAVE:    state_next = lrbc_pkg::ST_LOAD;
        lrbc_pkg::ST_LOAD:    state_next = lrbc_pkg::ST_FINISH;
        lrbc_pkg::ST_FLUSH: begin
          if (flush_restore) begin
            state_next = lrbc_pkg::ST_RESTORE;
          end else if (idx_last) begin
            state_next = lrbc_pkg::ST_FINISH;
          end
        end
        lrbc_pkg::ST_RESTORE: begin
          state_next = idx_last ? lrbc_pkg::ST_FINISH : lrbc_pkg::ST_FLUSH;
        end
        lrbc_pkg::ST_RESET:   state_next = lrbc_pkg::ST_FINISH;
        lrbc_pkg::ST_FINISH:  state_next = lrbc_pkg::ST_IDLE;
        default:              state_next = lrbc_pkg::ST_IDLE;
      endcase
    end
  end

  // Result produced by the current step, if any.
  always_comb begin
    pop      = 1'b0;
    produce  = 1'b0;
    finish   = 1'b0;
    prod_res = '{action: lrbc_pkg::ACT_DONE, slot: idx, guest: cur_guest};
    unique case (state)
      lrbc_pkg::ST_IDLE: begin
        pop = advance && !q_status.empty;
      end
      lrbc_pkg::ST_ACCESS: begin
        produce  = hit;
        prod_res = '{action: lrbc_pkg::ACT_DONE, slot: hit_slot, guest: cmd.guest};
      end
      lrbc_pkg::ST_EVICT: begin
        produce  = cur_dirty;
        prod_res = '{action: lrbc_pkg::ACT_WRITEBACK, slot: idx, guest: cur_guest};
      end
      lrbc_pkg::ST_OPEN: begin
        produce  = need_open;
        prod_res = '{action: lrbc_pkg::ACT_OPEN, slot: victim, guest: cmd.guest};
      end
      lrbc_pkg::ST_SAVE: begin
        produce  = !victim_vol && took_empty;
        prod_res = '{action: lrbc_pkg::ACT_SAVE, slot: victim, guest: cmd.guest};
      end
      lrbc_pkg::ST_LOAD: begin
        produce  = 1'b1;
        prod_res = '{action: (cmd.guest == '0) ? lrbc_pkg::ACT_ZERO : lrbc_pkg::ACT_LOAD,
                     slot: victim, guest: cmd.guest};
      end
      lrbc_pkg::ST_FLUSH: begin
        produce  = !flush_skip && cur_dirty;
        prod_res = '{action: lrbc_pkg::ACT_WRITEBACK, slot: idx, guest: cur_guest};
      end
      lrbc_pkg::ST_RESTORE: begin
        produce  = 1'b1;
        prod_res = '{action: lrbc_pkg::ACT_RESTORE, slot: idx, guest: cur_guest};
      end
      lrbc_pkg::ST_FINISH: begin
        finish = 1'b1;
      end
      default: begin
        produce = 1'b0;
      end
    endcase
  end

  // A held result moves on once the next one exists; the last one goes out
  // at the end of the command with the last flag, or a done result if none.
  assign count_ok = (count < lrbc_pkg::CNT_W'(lrbc_pkg::MAX_RESULTS));
  assign push     = advance && ((produce && count_ok && hold_valid) || finish);
  assign push_last = finish;
  always_comb begin
    if (finish && !hold_valid) begin
      push_res = '{action: lrbc_pkg::ACT_DONE, slot: '0, guest: '0};
    end else begin
      push_res = hold;
    end
  end

  // Sequencer state, binding state and result stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= lrbc_pkg::ST_IDLE;
      slot_valid    <= '0;
      slot_dirty    <= '0;
      guest_mapped  <= '0;
      stamp_counter <= '0;
      fresh_ptr     <= '0;
      frame_open    <= 1'b0;
      hold_valid    <= 1'b0;
      count         <= '0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;

      if (advance) begin
        unique case (state)
          lrbc_pkg::ST_IDLE: begin
            if (pop) begin
              cmd <= head;
              idx <= '0;
            end
          end
          lrbc_pkg::ST_ACCESS: begin
            if (hit) begin
              slot_stamp[hit_slot] <= stamp_counter;
              stamp_counter        <= stamp_counter + 1'b1;
              if (cmd.dirty) begin
                slot_dirty[hit_slot] <= 1'b1;
              end
            end else if (fresh_free) begin
              victim     <= fresh_ptr[SW-1:0];
              fresh_ptr  <= fresh_ptr + 1'b1;
              took_empty <= 1'b1;
            end else begin
              idx        <= '0;
              best       <= '0;
              best_stamp <= slot_stamp[0];
              took_empty <= 1'b0;
            end
          end
          lrbc_pkg::ST_SCAN: begin
            if (!cur_valid) begin
              victim     <= idx;
              took_empty <= 1'b1;
            end else begin
              best <= best_pick;
              if (scan_lower) begin
                best_stamp <= cur_stamp;
              end
              if (idx_last) begin
                idx    <= best_pick;
                victim <= best_pick;
              end else begin
                idx <= idx + 1'b1;
              end
            end
          end
          lrbc_pkg::ST_EVICT: begin
            guest_mapped[cur_guest] <= 1'b0;
          end
          lrbc_pkg::ST_BIND: begin
            slot_guest[victim]     <= cmd.guest;
            slot_valid[victim]     <= 1'b1;
            slot_stamp[victim]     <= stamp_counter;
            stamp_counter          <= stamp_counter + 1'b1;
            slot_dirty[victim]     <= cmd.dirty;
            guest_map[cmd.guest]    <= victim;
            guest_mapped[cmd.guest] <= 1'b1;
            need_open              <= !victim_vol && !frame_open;
            if (!victim_vol) begin
              frame_open <= 1'b1;
            end
          end
          lrbc_pkg::ST_FLUSH: begin
            if (!flush_skip && (cmd.kind == lrbc_pkg::CMD_FLUSH_REL)) begin
              guest_mapped[cur_guest] <= 1'b0;
              slot_valid[idx]         <= 1'b0;
              slot_dirty[idx]         <= 1'b0;
            end
            if (!flush_restore && !idx_last) begin
              idx <= idx + 1'b1;
            end
          end
          lrbc_pkg::ST_RESTORE: begin
            if (!idx_last) begin
              idx <= idx + 1'b1;
            end
          end
          lrbc_pkg::ST_RESET: begin
            slot_valid    <= '0;
            slot_dirty    <= '0;
            guest_mapped  <= '0;
            stamp_counter <= '0;
            fresh_ptr     <= '0;
            frame_open    <= 1'b0;
          end
          default: begin
            cmd <= cmd;
          end
        endcase

        // Results past the limit are dropped; the held one stays the final one.
        if (produce && count_ok) begin
          hold       <= prod_res;
          hold_valid <= 1'b1;
          count      <= count + 1'b1;
        end
        if (finish) begin
          hold_valid <= 1'b0;
          count      <= '0;
        end
      end

      // Output register.
      if (push) begin
        out_valid <= 1'b1;
        out_res   <= push_res;
        out_last  <= push_last;
      end else if (!rsp_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign rsp_valid   = out_valid;
  assign action      = out_res.action;
  assign slot        = lrbc_pkg::SLOT_PORT_W'(out_res.slot);
  assign guest_index = out_res.guest;
  assign last        = out_last;

endmodule

// ----- dv/tb_lru_register_binding_cache.sv -----
module tb_lru_register_binding_cache;

  // Mode codes that the block ignores; they only produce a done result.
  localparam logic [lrbc_pkg::MODE_W-1:0] MODE_IGNORED_6 = 3'd6;
  localparam logic [lrbc_pkg::MODE_W-1:0] MODE_IGNORED_7 = 3'd7;

  localparam int RANDOM_ITEMS   = 185;
  localparam int QUIET_TAIL     = 30;
  localparam int DRAIN_CYCLES   = 60;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int REPORT_LIMIT   = 10;
  localparam int DIRECTED_ROWS  = 25;

  typedef struct packed {
    lrbc_pkg::action_t                 act;
    logic [lrbc_pkg::SLOT_PORT_W-1:0]  slot_no;
    logic [lrbc_pkg::GUEST_W-1:0]      guest;
    logic                              is_last;
  } binding_result_t;

  typedef struct packed {
    logic [lrbc_pkg::MODE_W-1:0]       m;
    logic [lrbc_pkg::GUEST_W-1:0]      g;
    logic                              typed;
    lrbc_pkg::action_t                 act;
    logic [lrbc_pkg::SLOT_PORT_W-1:0]  slot_no;
    logic [lrbc_pkg::GUEST_W-1:0]      guest;
  } stim_row_t;

  logic                              clk = 1'b0;
  logic                              rst;
  logic                              req_valid;
  logic                              req_stall;
  logic [lrbc_pkg::MODE_W-1:0]       mode;
  logic [lrbc_pkg::GUEST_W-1:0]      guest_reg;
  logic                              rsp_valid;
  logic                              rsp_stall = 1'b0;
  logic [lrbc_pkg::ACT_W-1:0]        action;
  logic [lrbc_pkg::SLOT_PORT_W-1:0]  slot;
  logic [lrbc_pkg::GUEST_W-1:0]      guest_index;
  logic                              last;

  // Shadow copy of the binding state.
  bit [lrbc_pkg::GUEST_W-1:0]  bind_guest [lrbc_pkg::NUM_SLOTS];
  bit                          bind_valid [lrbc_pkg::NUM_SLOTS];
  bit                          bind_dirty [lrbc_pkg::NUM_SLOTS];
  bit [lrbc_pkg::STAMP_W-1:0]  bind_stamp [lrbc_pkg::NUM_SLOTS];
  bit [lrbc_pkg::SLOT_W-1:0]   guest_slot [lrbc_pkg::NUM_GUESTS];
  bit                          guest_bound [lrbc_pkg::NUM_GUESTS];
  bit [lrbc_pkg::STAMP_W-1:0]  stamp_ctr;
  int                          fresh_next;
  bit                          frame_up;

  binding_result_t          step_actions [$];
  binding_result_t          expected_actions [$];
  int                       mismatch_count = 0;
  int                       idle_cycles = 0;
  int                       stall_left = 0;
  int                       calm_left = 0;
  bit                       quiet = 1'b0;

  // Directed rows: empty flush, ignored modes, first binds, hit, fill of every
  // slot, LRU eviction, the flush variants and a soft reset.
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{lrbc_pkg::MODE_FLUSH,         5'd0,  1'b1, lrbc_pkg::ACT_DONE, 4'd0, 5'd0},
    '{MODE_IGNORED_6,               5'd31, 1'b1, lrbc_pkg::ACT_DONE, 4'd0, 5'd0},
    '{MODE_IGNORED_7,               5'd0,  1'b1, lrbc_pkg::ACT_DONE, 4'd0, 5'd0},
    '{lrbc_pkg::MODE_READ,          5'd0,  1'b1, lrbc_pkg::ACT_ZERO, 4'd0, 5'd0},
    '{lrbc_pkg::MODE_WRITE,         5'd31, 1'b1, lrbc_pkg::ACT_LOAD, 4'd1, 5'd31},
    '{lrbc_pkg::MODE_WRITE,         5'd0,  1'b1, lrbc_pkg::ACT_DONE, 4'd0, 5'd0},
    '{lrbc_pkg::MODE_WRITE,         5'd1,  1'b0, lrbc_pkg::ACT_DONE, 4'd0, 5'd0},
    '{lrbc_pkg::MODE_WRITE,         5'd2,  1'b0, lrbc_pkg::ACT_DONE, 4'd0, 5'd0},
    '{lrbc_pkg::MODE_WRITE,         5'd3,  1'b0, lrbc_pkg::ACT_DONE, 4'd0, 5'd0},
    '{lrbc_pkg::MODE_WRITE,         5'd4,  1'b0, lrbc_pkg::ACT_DONE, 4'd0, 5'd0},
    '{lrbc_pkg::MODE_WRITE,         5'd5,  1'b0, lrbc_pkg::ACT_DONE, 4'd0, 5'd0},
    '{lrbc_pkg::MODE_WRITE,         5'd6,  1'b0, lrbc_pkg::ACT_DONE, 4'd0, 5'd0},
    '{lrbc_pkg::MODE_WRITE,         5'd7,  1'b0, lrbc_pkg::ACT_DONE, 4'd0, 5'd0},
    '{lrbc_pkg::MODE_WRITE,         5'd8,  1'b0, lrbc_pkg::ACT_DONE, 4'd0, 5'd0},
    '{lrbc_pkg::MODE_WRITE,         5'd9,  1'b0, lrbc_pkg::ACT_DONE, 4'd0, 5'd0},
    '{lrbc_pkg::MODE_WRITE,         5'd10, 1'b0, lrbc_pkg::ACT_DONE, 4'd0, 5'd0},
    '{lrbc_pkg::MODE_WRITE,         5'd11, 1'b0, lrbc_pkg::ACT_DONE, 4'd0, 5'd0},
    '{lrbc_pkg::MODE_WRITE,         5'd12, 1'b0, lrbc_pkg::ACT_DONE, 4'd0, 5'd0},
    '{lrbc_pkg::MODE_WRITE,         5'd13, 1'b0, lrbc_pkg::ACT_DONE, 4'd0, 5'd0},
    '{lrbc_pkg::MODE_WRITE,         5'd14, 1'b0, lrbc_pkg::ACT_DONE, 4'd0, 5'd0},
    '{lrbc_pkg::MODE_READ,          5'd20, 1'b0, lrbc_pkg::ACT_DONE, 4'd0, 5'd0},
    '{lrbc_pkg::MODE_FLUSH_RESTORE, 5'd0,  1'b0, lrbc_pkg::ACT_DONE, 4'd0, 5'd0},
    '{lrbc_pkg::MODE_FLUSH_RELEASE, 5'd0,  1'b0, lrbc_pkg::ACT_DONE, 4'd0, 5'd0},
    '{lrbc_pkg::MODE_WRITE,         5'd21, 1'b0, lrbc_pkg::ACT_DONE, 4'd0, 5'd0},
    '{lrbc_pkg::MODE_RESET,         5'd17, 1'b1, lrbc_pkg::ACT_DONE, 4'd0, 5'd0}
  };

  lru_register_binding_cache DUT (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .mode        (mode),
    .guest_reg   (guest_reg),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .action      (action),
    .slot        (slot),
    .guest_index (guest_index),
    .last        (last)
  );

  always #10 clk = ~clk;

  // Queue one action for the current item; anything past the cap is dropped.
  function automatic void note_action(lrbc_pkg::action_t a, int s,
                                      bit [lrbc_pkg::GUEST_W-1:0] g);
    binding_result_t r;
    if (step_actions.size() < lrbc_pkg::MAX_RESULTS) begin
      r.act     = a;
      r.slot_no = s[lrbc_pkg::SLOT_PORT_W-1:0];
      r.guest   = g;
      r.is_last = 1'b0;
      step_actions.insert(step_actions.size(), r);
    end
  endfunction

  function automatic void clear_bindings();
    int i;
    for (i = 0; i < lrbc_pkg::NUM_SLOTS; i++) begin
      bind_guest[i] = '0;
      bind_valid[i] = 1'b0;
      bind_dirty[i] = 1'b0;
      bind_stamp[i] = '0;
    end
    for (i = 0; i < lrbc_pkg::NUM_GUESTS; i++) begin
      guest_slot[i]  = '0;
      guest_bound[i] = 1'b0;
    end
    stamp_ctr  = '0;
    fresh_next = 0;
    frame_up   = 1'b0;
  endfunction

  // Read or write of one guest register: hit, or bind into a fresh, empty
  // or least recently used slot.
  function automatic void bind_access(bit [lrbc_pkg::GUEST_W-1:0] g, bit dirty);
    int s;
    int i;
    bit took_empty;
    bit [lrbc_pkg::GUEST_W-1:0] old;
    took_empty = 1'b0;
    if (guest_bound[g]) begin
      s = int'(guest_slot[g]);
      bind_stamp[s] = stamp_ctr;
      stamp_ctr = stamp_ctr + 1;
      bind_dirty[s] = bind_dirty[s] | dirty;
      note_action(lrbc_pkg::ACT_DONE, s, g);
      return;
    end
    if (fresh_next < lrbc_pkg::NUM_SLOTS) begin
      s = fresh_next;
      fresh_next++;
      took_empty = 1'b1;
    end else begin
      s = 0;
      for (i = 0; i < lrbc_pkg::NUM_SLOTS; i++) begin
        if (!bind_valid[i]) begin
          s = i;
          took_empty = 1'b1;
          break;
        end
        if (bind_stamp[i] < bind_stamp[s]) s = i;
      end
      if (!took_empty) begin
        old = bind_guest[s];
        if (bind_dirty[s]) note_action(lrbc_pkg::ACT_WRITEBACK, s, old);
        guest_bound[old] = 1'b0;
      end
    end
    bind_guest[s] = g;
    bind_valid[s] = 1'b1;
    bind_stamp[s] = stamp_ctr;
    stamp_ctr = stamp_ctr + 1;
    bind_dirty[s] = dirty;
    guest_slot[g] = s[lrbc_pkg::SLOT_W-1:0];
    guest_bound[g] = 1'b1;
    // Preserved slots open the frame once and are saved when taken empty.
    if (s >= lrbc_pkg::NUM_VOLATILE) begin
      if (!frame_up) begin
        frame_up = 1'b1;
        note_action(lrbc_pkg::ACT_OPEN, s, g);
      end
      if (took_empty) note_action(lrbc_pkg::ACT_SAVE, s, g);
    end
    note_action((g == 0) ? lrbc_pkg::ACT_ZERO : lrbc_pkg::ACT_LOAD, s, g);
  endfunction

  // Flush variants walk the slots in index order.
  function automatic void flush_bindings(bit [lrbc_pkg::MODE_W-1:0] m);
    int i;
    bit [lrbc_pkg::GUEST_W-1:0] g;
    for (i = 0; i < lrbc_pkg::NUM_SLOTS; i++) begin
      if (m == lrbc_pkg::MODE_FLUSH_RELEASE && i >= lrbc_pkg::NUM_VOLATILE) continue;
      if (!bind_valid[i]) continue;
      g = bind_guest[i];
      if (bind_dirty[i]) note_action(lrbc_pkg::ACT_WRITEBACK, i, g);
      if (m == lrbc_pkg::MODE_FLUSH_RESTORE && i >= lrbc_pkg::NUM_VOLATILE)
        note_action(lrbc_pkg::ACT_RESTORE, i, g);
      if (m == lrbc_pkg::MODE_FLUSH_RELEASE) begin
        guest_bound[g] = 1'b0;
        bind_valid[i]  = 1'b0;
        bind_dirty[i]  = 1'b0;
      end
    end
  endfunction

  // Work out every action that one accepted item causes.
  function automatic void predict_bindings(bit [lrbc_pkg::MODE_W-1:0] m,
                                           bit [lrbc_pkg::GUEST_W-1:0] g);
    step_actions.delete();
    case (m)
      lrbc_pkg::MODE_READ: bind_access(g, 1'b0);
      lrbc_pkg::MODE_WRITE: bind_access(g, g != 0);
      lrbc_pkg::MODE_FLUSH, lrbc_pkg::MODE_FLUSH_RELEASE,
      lrbc_pkg::MODE_FLUSH_RESTORE: flush_bindings(m);
      lrbc_pkg::MODE_RESET: clear_bindings();
      default: ;
    endcase
    if (step_actions.size() == 0) note_action(lrbc_pkg::ACT_DONE, 0, '0);
    step_actions[step_actions.size() - 1].is_last = 1'b1;
  endfunction

  // Drive one item, wait for its transfer, then record what it should cause.
  task automatic send_item(input logic [lrbc_pkg::MODE_W-1:0] m,
                           input logic [lrbc_pkg::GUEST_W-1:0] g,
                           input bit typed, input binding_result_t typed_res,
                           input bit idle_ok);
    int k;
    if (idle_ok && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    req_valid <= 1'b1;
    mode      <= m;
    guest_reg <= g;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    predict_bindings(m, g);
    if (typed) begin
      expected_actions.insert(expected_actions.size(), typed_res);
    end else begin
      for (k = 0; k < step_actions.size(); k++)
        expected_actions.insert(expected_actions.size(), step_actions[k]);
    end
  endtask

  // Receiver stalls in short bursts, with calm stretches in between.
  always @(posedge clk) begin
    if (rst || quiet) begin
      rsp_stall  <= 1'b0;
      stall_left <= 0;
      calm_left  <= 0;
    end else if (stall_left > 0) begin
      rsp_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (calm_left > 0) begin
      rsp_stall <= 1'b0;
      calm_left <= calm_left - 1;
    end else begin
      case ($urandom_range(0, 9))
        0, 1: begin
          rsp_stall  <= 1'b1;
          stall_left <= $urandom_range(0, 3);
        end
        2: begin
          rsp_stall <= 1'b0;
          calm_left <= $urandom_range(10, 40);
        end
        default: rsp_stall <= 1'b0;
      endcase
    end
  end

  // Compare each result transfer with the oldest expected action.
  always @(posedge clk) begin
    binding_result_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_actions.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("unexpected result: act=%0d slot=%0d guest=%0d last=%0b",
                   action, slot, guest_index, last);
      end else begin
        want = expected_actions.pop_front();
        if (action !== want.act || slot !== want.slot_no ||
            guest_index !== want.guest || last !== want.is_last) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT) begin
            $write("result differs: expected act=%0d slot=%0d guest=%0d last=%0b",
                   want.act, want.slot_no, want.guest, want.is_last);
            $display(", got act=%0d slot=%0d guest=%0d last=%0b",
                     action, slot, guest_index, last);
          end
        end
      end
    end
  end

  // Watchdog: too long without any transfer ends the run.
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", idle_cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Reset, directed rows, random traffic, then drain.
  initial begin
    binding_result_t typed_res;
    logic [lrbc_pkg::MODE_W-1:0] m;
    logic [lrbc_pkg::GUEST_W-1:0] g;
    int pick;
    int n;
    int r;
    rst       = 1'b1;
    req_valid = 1'b0;
    mode      = lrbc_pkg::MODE_READ;
    guest_reg = '0;
    clear_bindings();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (r = 0; r < DIRECTED_ROWS; r++) begin
      typed_res.act     = directed_rows[r].act;
      typed_res.slot_no = directed_rows[r].slot_no;
      typed_res.guest   = directed_rows[r].guest;
      typed_res.is_last = 1'b1;
      send_item(directed_rows[r].m, directed_rows[r].g, directed_rows[r].typed,
                typed_res, 1'b1);
    end

    // Mostly accesses, with a hot set of low guests so hits and evictions mix.
    typed_res = '0;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      quiet = (n >= RANDOM_ITEMS - QUIET_TAIL);
      pick  = $urandom_range(0, 99);
      g     = lrbc_pkg::GUEST_W'($urandom_range(0, lrbc_pkg::NUM_GUESTS - 1));
      if (pick < 82) begin
        m = (pick < 41) ? lrbc_pkg::MODE_READ : lrbc_pkg::MODE_WRITE;
        if ($urandom_range(0, 2) == 0) g = lrbc_pkg::GUEST_W'($urandom_range(0, 7));
      end else if (pick < 88) begin
        m = lrbc_pkg::MODE_FLUSH;
      end else if (pick < 93) begin
        m = lrbc_pkg::MODE_FLUSH_RESTORE;
      end else if (pick < 96) begin
        m = lrbc_pkg::MODE_FLUSH_RELEASE;
      end else if (pick < 98) begin
        m = lrbc_pkg::MODE_RESET;
      end else begin
        m = (pick == 98) ? MODE_IGNORED_6 : MODE_IGNORED_7;
      end
      send_item(m, g, 1'b0, typed_res, !quiet && ((n / 20) % 3 != 2));
    end
    req_valid <= 1'b0;

    while (expected_actions.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
